>>> design/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg: shared types and constants of the LED and buzzer pattern sequencer
// Command kinds, pattern record, configuration bundle, back-end states and
// register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lbps_pkg;

	// Input action codes
	localparam logic [1:0] ACT_TICK        = 2'd0;
	localparam logic [1:0] ACT_QUEUE       = 2'd1;
	localparam logic [1:0] ACT_CLEAR_QUEUE = 2'd2;
	localparam logic [1:0] ACT_SUCCESS     = 2'd3;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_ENABLE       = 3'd0;
	localparam logic [2:0] REG_LED_ENABLED  = 3'd1;
	localparam logic [2:0] REG_RGB_MODE     = 3'd2;
	localparam logic [2:0] REG_ACTIVE_HIGH  = 3'd3;
	localparam logic [2:0] REG_BUZZER_EN    = 3'd4;
	localparam logic [2:0] REG_DEFAULT_FREQ = 3'd5;

	localparam logic [15:0] DEFAULT_FREQ_RESET = 16'd2000;

	// Pattern timing constants
	localparam logic [16:0] PHASE_MAX      = 17'h1FFFF;
	localparam logic [7:0]  REPEAT_FOREVER = 8'hFF;

	// Color bits
	localparam logic [2:0] COLOR_RED   = 3'b001;
	localparam logic [2:0] COLOR_GREEN = 3'b010;
	localparam logic [2:0] COLOR_BLUE  = 3'b100;

	// Command queue between front and back
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_QUEUE,
		CMD_CLEAR_QUEUE,
		CMD_SUCCESS
	} cmd_kind_t;

	typedef struct packed {
		logic [15:0] on_ms;
		logic [15:0] off_ms;
		logic [15:0] beep_ms;
		logic [15:0] beep_freq_hz;
		logic [7:0]  repeat_count;
		logic [2:0]  color;
	} pattern_t;

	typedef struct packed {
		cmd_kind_t kind;
		pattern_t  pat;
	} cmd_t;

	typedef struct packed {
		logic        enable;
		logic        led_enabled;
		logic        rgb_mode;
		logic        active_high;
		logic        buzzer_enabled;
		logic [15:0] default_beep_freq_hz;
	} cfg_t;

	typedef enum logic {
		BK_RUN,
		BK_FETCH
	} back_state_t;

endpackage

`default_nettype wire

>>> design/lbps_channels.sv
// ----------------------------------------------------------------------------
// lbps channels: request and response handshake interfaces
// Each carries valid, ready and the payload fields of one word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbps_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] on_ms;
	logic [15:0] off_ms;
	logic [15:0] beep_ms;
	logic [15:0] beep_freq_hz;
	logic [7:0]  repeat_count;
	logic [2:0]  color;

	modport source (output valid, action, on_ms, off_ms, beep_ms, beep_freq_hz,
		repeat_count, color, input ready);
	modport sink (input valid, action, on_ms, off_ms, beep_ms, beep_freq_hz,
		repeat_count, color, output ready);
endinterface

interface lbps_rsp_if #(
	parameter int CNT_W = 4
);
	logic             valid;
	logic             ready;
	logic             red_level;
	logic             green_level;
	logic             blue_level;
	logic             mono_level;
	logic             buzzer_on;
	logic [15:0]      buzzer_freq_hz;
	logic             pattern_active;
	logic [CNT_W-1:0] queue_level;
	logic             dropped;

	modport source (output valid, red_level, green_level, blue_level, mono_level,
		buzzer_on, buzzer_freq_hz, pattern_active, queue_level, dropped, input ready);
	modport sink (input valid, red_level, green_level, blue_level, mono_level,
		buzzer_on, buzzer_freq_hz, pattern_active, queue_level, dropped, output ready);
endinterface

`default_nettype wire

>>> design/lbps_front.sv
// ----------------------------------------------------------------------------
// lbps_front: request intake
// Accepts request words, decodes the action into a command kind and holds
// the commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lbps_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lbps_req_if.sink          req,
	output lbps_pkg::cmd_t    cmd,
	output logic              cmd_valid,
	input  wire logic         cmd_pop
);

	lbps_pkg::cmd_t                    fifo_q [lbps_pkg::CMD_DEPTH];
	logic [lbps_pkg::CMD_PTR_W-1:0]    wr_ptr_q;
	logic [lbps_pkg::CMD_PTR_W-1:0]    rd_ptr_q;
	logic [lbps_pkg::CMD_CNT_W-1:0]    count_q;
	lbps_pkg::cmd_t                    in_cmd;
	logic                              push;
	logic                              pop;

	// Classify the incoming word
	always_comb begin
		in_cmd.pat.on_ms        = req.on_ms;
		in_cmd.pat.off_ms       = req.off_ms;
		in_cmd.pat.beep_ms      = req.beep_ms;
		in_cmd.pat.beep_freq_hz = req.beep_freq_hz;
		in_cmd.pat.repeat_count = req.repeat_count;
		in_cmd.pat.color        = req.color;
		case (req.action)
			lbps_pkg::ACT_TICK:        in_cmd.kind = lbps_pkg::CMD_TICK;
			lbps_pkg::ACT_QUEUE:       in_cmd.kind = lbps_pkg::CMD_QUEUE;
			lbps_pkg::ACT_CLEAR_QUEUE: in_cmd.kind = lbps_pkg::CMD_CLEAR_QUEUE;
			lbps_pkg::ACT_SUCCESS:     in_cmd.kind = lbps_pkg::CMD_SUCCESS;
			default:                   in_cmd.kind = lbps_pkg::CMD_TICK;
		endcase
	end

	assign req.ready = (count_q != lbps_pkg::CMD_CNT_W'(lbps_pkg::CMD_DEPTH));
	assign push      = req.valid && req.ready;
	assign pop       = cmd_pop && cmd_valid;
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	// Store command words
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= lbps_pkg::CMD_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= lbps_pkg::CMD_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= lbps_pkg::CMD_CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= lbps_pkg::CMD_CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/lbps_back.sv
// ----------------------------------------------------------------------------
// lbps_back: pattern ring and player
// Executes commands: keeps the pattern ring queue, plays the current pattern
// on ticks, runs the success beep and registers one response word a command.
// ----------------------------------------------------------------------------
`default_nettype none

module lbps_back #(
	parameter int QUEUE_DEPTH     = 8,
	parameter int SUCCESS_BEEP_MS = 80,
	parameter int SUCCESS_FREQ_HZ = 2800
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lbps_pkg::cfg_t cfg,
	input  wire lbps_pkg::cmd_t cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_pop,
	lbps_rsp_if.source          rsp
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SBL_W = $clog2(SUCCESS_BEEP_MS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	// Pattern ring memory
	lbps_pkg::pattern_t ring_mem [QUEUE_DEPTH];
	lbps_pkg::pattern_t rd_data_q;

	// Player state
	lbps_pkg::back_state_t bst_q, bst_n;
	lbps_pkg::pattern_t    cur_q, n_cur;
	logic [16:0]           phase_q, n_phase;
	logic [7:0]            done_q, n_done;
	logic                  playing_q, n_playing;
	logic [SBL_W-1:0]      sbl_q, n_sbl;
	logic [2:0]            color_q, n_color;
	logic                  pbz_on_q, n_pbz_on;
	logic [15:0]           pbz_freq_q, n_pbz_freq;
	logic [IDX_W-1:0]      head_q, n_head;
	logic [IDX_W-1:0]      tail_q, n_tail;
	logic [CNT_W-1:0]      cnt_q, n_cnt;

	// Response register
	logic             ov_q;
	logic             red_q, green_q, blue_q, mono_q, bz_on_q, active_q, dropped_q;
	logic [15:0]      bz_freq_q;
	logic [CNT_W-1:0] level_q;

	// Step results
	logic             exec;
	logic             out_free;
	logic             need_fetch;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic             bz_call, bz_on_req, stopped, dropped;
	logic [15:0]      bz_f_req;
	logic [16:0]      cyc_len, ph_inc;
	logic             dark;
	logic             o_red, o_green, o_blue, o_mono, o_bz_on;
	logic [15:0]      o_bz_freq;

	// Sequence command execution; a tick that starts a pattern reads the ring first
	assign out_free   = !ov_q || rsp.ready;
	assign need_fetch = (cmd.kind == lbps_pkg::CMD_TICK) && cfg.enable && !playing_q &&
		(cnt_q != '0);

	always_comb begin
		bst_n = bst_q;
		exec  = 1'b0;
		case (bst_q)
			lbps_pkg::BK_RUN: begin
				if (cmd_valid && out_free) begin
					if (need_fetch) begin
						bst_n = lbps_pkg::BK_FETCH;
					end else begin
						exec = 1'b1;
					end
				end
			end
			lbps_pkg::BK_FETCH: begin
				if (out_free) begin
					exec  = 1'b1;
					bst_n = lbps_pkg::BK_RUN;
				end
			end
			default: bst_n = lbps_pkg::BK_RUN;
		endcase
	end

	assign cmd_pop = exec;

	// Compute the next player state and the response word
	always_comb begin
		n_cur      = cur_q;
		n_phase    = phase_q;
		n_done     = done_q;
		n_playing  = playing_q;
		n_sbl      = sbl_q;
		n_color    = color_q;
		n_pbz_on   = pbz_on_q;
		n_pbz_freq = pbz_freq_q;
		n_head     = head_q;
		n_tail     = tail_q;
		n_cnt      = cnt_q;
		bz_call    = 1'b0;
		bz_on_req  = 1'b0;
		bz_f_req   = '0;
		stopped    = 1'b0;
		dropped    = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = tail_q;
		cyc_len    = {1'b0, cur_q.on_ms} + {1'b0, cur_q.off_ms};
		ph_inc     = (phase_q < lbps_pkg::PHASE_MAX) ? 17'(phase_q + 17'd1) : phase_q;

		case (cmd.kind)
			lbps_pkg::CMD_TICK: begin
				if (sbl_q != '0) begin
					n_sbl = SBL_W'(sbl_q - 1'b1);
				end
				if (cfg.enable) begin
					if (playing_q) begin
						n_phase = ph_inc;
						if ((cyc_len != '0) && (ph_inc >= cyc_len)) begin
							n_done = 8'(done_q + 8'd1);
							if ((cur_q.repeat_count != lbps_pkg::REPEAT_FOREVER) &&
								(n_done >= cur_q.repeat_count)) begin
								stopped = 1'b1;
							end else begin
								n_phase = '0;
							end
						end
						if (stopped) begin
							n_playing = 1'b0;
							n_color   = '0;
							bz_call   = 1'b1;
						end else begin
							n_color   = (n_phase < {1'b0, cur_q.on_ms}) ? cur_q.color : 3'b000;
							bz_call   = 1'b1;
							bz_on_req = (cur_q.beep_ms != '0) && (n_phase < {1'b0, cur_q.beep_ms});
							bz_f_req  = cur_q.beep_freq_hz;
						end
					end else if (bst_q == lbps_pkg::BK_FETCH) begin
						// Start the oldest queued pattern
						n_cur     = rd_data_q;
						n_head    = (head_q == LAST_IDX) ? '0 : IDX_W'(head_q + 1'b1);
						n_cnt     = CNT_W'(cnt_q - 1'b1);
						n_done    = '0;
						n_phase   = '0;
						n_playing = 1'b1;
						n_color   = (rd_data_q.on_ms != '0) ? rd_data_q.color : 3'b000;
						if (rd_data_q.beep_ms != '0) begin
							bz_call   = 1'b1;
							bz_on_req = 1'b1;
							bz_f_req  = rd_data_q.beep_freq_hz;
						end
					end
				end
			end
			lbps_pkg::CMD_SUCCESS: begin
				n_playing = 1'b0;
				n_color   = '0;
				bz_call   = 1'b1;
				n_head    = '0;
				n_tail    = '0;
				n_cnt     = '0;
			end
			lbps_pkg::CMD_QUEUE, lbps_pkg::CMD_CLEAR_QUEUE: begin
				if (cmd.kind == lbps_pkg::CMD_CLEAR_QUEUE) begin
					n_head = '0;
					n_tail = '0;
					n_cnt  = '0;
				end
				if (cfg.enable) begin
					if (n_cnt >= CNT_W'(QUEUE_DEPTH)) begin
						dropped = 1'b1;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = n_tail;
						n_tail    = (n_tail == LAST_IDX) ? '0 : IDX_W'(n_tail + 1'b1);
						n_cnt     = CNT_W'(n_cnt + 1'b1);
					end
				end
			end
			default: ;
		endcase

		// Change the pattern buzzer; any change ends the success beep
		if (bz_call && cfg.buzzer_enabled && (bz_on_req != pbz_on_q)) begin
			n_pbz_on   = bz_on_req;
			n_pbz_freq = !bz_on_req ? 16'd0 :
				((bz_f_req != '0) ? bz_f_req : cfg.default_beep_freq_hz);
			n_sbl      = '0;
		end

		// Arm the success beep
		if ((cmd.kind == lbps_pkg::CMD_SUCCESS) && cfg.enable && cfg.buzzer_enabled) begin
			n_sbl = SBL_W'(SUCCESS_BEEP_MS);
		end

		// Map the shown color onto pins
		dark    = !cfg.active_high;
		o_red   = 1'b0;
		o_green = 1'b0;
		o_blue  = 1'b0;
		o_mono  = 1'b0;
		if (cfg.led_enabled && cfg.rgb_mode) begin
			o_red   = ((n_color & lbps_pkg::COLOR_RED) != '0) ^ dark;
			o_green = ((n_color & lbps_pkg::COLOR_GREEN) != '0) ^ dark;
			o_blue  = ((n_color & lbps_pkg::COLOR_BLUE) != '0) ^ dark;
		end else if (cfg.led_enabled) begin
			o_mono  = (n_color != '0) ^ dark;
		end

		// Pattern buzzer wins over the success beep
		o_bz_on   = 1'b0;
		o_bz_freq = '0;
		if (cfg.buzzer_enabled) begin
			if (n_pbz_on) begin
				o_bz_on   = 1'b1;
				o_bz_freq = n_pbz_freq;
			end else if (n_sbl != '0) begin
				o_bz_on   = 1'b1;
				o_bz_freq = 16'(SUCCESS_FREQ_HZ);
			end
		end
	end

	// Write and read the ring
	always_ff @(posedge clk) begin
		if (exec && mem_we) begin
			ring_mem[mem_waddr] <= cmd.pat;
		end
		rd_data_q <= ring_mem[head_q];
	end

	// Hold the back-end state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= lbps_pkg::BK_RUN;
		end else begin
			bst_q <= bst_n;
		end
	end

	// Update player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			phase_q    <= '0;
			done_q     <= '0;
			playing_q  <= 1'b0;
			sbl_q      <= '0;
			color_q    <= '0;
			pbz_on_q   <= 1'b0;
			pbz_freq_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
		end else if (exec) begin
			cur_q      <= n_cur;
			phase_q    <= n_phase;
			done_q     <= n_done;
			playing_q  <= n_playing;
			sbl_q      <= n_sbl;
			color_q    <= n_color;
			pbz_on_q   <= n_pbz_on;
			pbz_freq_q <= n_pbz_freq;
			head_q     <= n_head;
			tail_q     <= n_tail;
			cnt_q      <= n_cnt;
		end
	end

	// Hold the response word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (exec) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			red_q     <= o_red;
			green_q   <= o_green;
			blue_q    <= o_blue;
			mono_q    <= o_mono;
			bz_on_q   <= o_bz_on;
			bz_freq_q <= o_bz_freq;
			active_q  <= n_playing;
			level_q   <= n_cnt;
			dropped_q <= dropped;
		end
	end

	assign rsp.valid          = ov_q;
	assign rsp.red_level      = red_q;
	assign rsp.green_level    = green_q;
	assign rsp.blue_level     = blue_q;
	assign rsp.mono_level     = mono_q;
	assign rsp.buzzer_on      = bz_on_q;
	assign rsp.buzzer_freq_hz = bz_freq_q;
	assign rsp.pattern_active = active_q;
	assign rsp.queue_level    = level_q;
	assign rsp.dropped        = dropped_q;

endmodule

`default_nettype wire

>>> design/led_buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// led_buzzer_pattern_sequencer: LED and buzzer feedback pattern engine
// Configuration registers, request intake and pattern player.
// ----------------------------------------------------------------------------
// Each request word (tick, queue, clear-then-queue, success) yields one
// response word with the LED pin levels, buzzer state, playing flag, queue
// level and drop flag after that word. Words pass through a two-entry
// command queue to the player. A tick that starts a queued pattern first
// passes a fetch state, as the head of the pattern ring is read through a
// registered memory port; other words execute directly, so the sustained
// rate is one word per cycle but for starts and response stalls. The pattern
// ring needs no clearing pass after reset. Registers (byte address 4*i):
// enable, led_enabled, rgb_mode, active_high, buzzer_enabled,
// default_beep_freq_hz; write them only while no word is in flight.
`default_nettype none

module led_buzzer_pattern_sequencer #(
	parameter int QUEUE_DEPTH     = 8,
	parameter int SUCCESS_BEEP_MS = 80,
	parameter int SUCCESS_FREQ_HZ = 2800
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lbps_req_if.sink         req,
	lbps_rsp_if.source       rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	lbps_pkg::cfg_t cfg_q;
	lbps_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_pop;
	logic           cfg_wr;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable               <= 1'b1;
			cfg_q.led_enabled          <= 1'b1;
			cfg_q.rgb_mode             <= 1'b1;
			cfg_q.active_high          <= 1'b1;
			cfg_q.buzzer_enabled       <= 1'b1;
			cfg_q.default_beep_freq_hz <= lbps_pkg::DEFAULT_FREQ_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				lbps_pkg::REG_ENABLE:       cfg_q.enable               <= pwdata[0];
				lbps_pkg::REG_LED_ENABLED:  cfg_q.led_enabled          <= pwdata[0];
				lbps_pkg::REG_RGB_MODE:     cfg_q.rgb_mode             <= pwdata[0];
				lbps_pkg::REG_ACTIVE_HIGH:  cfg_q.active_high          <= pwdata[0];
				lbps_pkg::REG_BUZZER_EN:    cfg_q.buzzer_enabled       <= pwdata[0];
				lbps_pkg::REG_DEFAULT_FREQ: cfg_q.default_beep_freq_hz <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (reg_idx)
			lbps_pkg::REG_ENABLE:       prdata = {31'd0, cfg_q.enable};
			lbps_pkg::REG_LED_ENABLED:  prdata = {31'd0, cfg_q.led_enabled};
			lbps_pkg::REG_RGB_MODE:     prdata = {31'd0, cfg_q.rgb_mode};
			lbps_pkg::REG_ACTIVE_HIGH:  prdata = {31'd0, cfg_q.active_high};
			lbps_pkg::REG_BUZZER_EN:    prdata = {31'd0, cfg_q.buzzer_enabled};
			lbps_pkg::REG_DEFAULT_FREQ: prdata = {16'd0, cfg_q.default_beep_freq_hz};
			default:                    prdata = '0;
		endcase
	end

	lbps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	lbps_back #(
		.QUEUE_DEPTH     (QUEUE_DEPTH),
		.SUCCESS_BEEP_MS (SUCCESS_BEEP_MS),
		.SUCCESS_FREQ_HZ (SUCCESS_FREQ_HZ)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

	// A request is dropped only against a full queue
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.dropped) |-> (rsp.queue_level == CNT_W'(QUEUE_DEPTH)))
		else $error("drop reported with room in queue");

	// Queue level never exceeds the ring depth
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.queue_level <= CNT_W'(QUEUE_DEPTH)))
		else $error("queue level beyond depth");

	// A silent buzzer shows frequency zero
	a_silent_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.buzzer_on) |-> (rsp.buzzer_freq_hz == 16'd0))
		else $error("frequency shown while buzzer silent");

	// A command is consumed only when the front holds one
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LED and buzzer pattern sequencer
// Drives tick, queue, clear-then-queue and success words through the request
// channel with bursty timing, stalls the response channel, and checks every
// response word field by field against an in-bench model of the player, the
// pattern ring and the success beep, across several register setups.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import lbps_pkg::*;

	localparam int          RING_DEPTH      = 8;
	localparam logic [6:0]  SUCCESS_MS      = 7'd80;
	localparam logic [15:0] SUCCESS_TONE_HZ = 16'd2800;
	localparam int          QUIET_LIMIT     = 2000;
	localparam int          TAIL_CYCLES     = 16;

	typedef struct packed {
		logic [1:0] action;
		pattern_t   pat;
	} word_in_t;

	typedef struct packed {
		logic        red;
		logic        green;
		logic        blue;
		logic        mono;
		logic        buzz;
		logic [15:0] freq;
		logic        active;
		logic [3:0]  level;
		logic        dropped;
	} word_out_t;

	typedef struct {
		word_in_t  word;
		int        times;
		bit        typed;
		word_out_t levels;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	lbps_req_if req_bus ();
	lbps_rsp_if #(.CNT_W(4)) rsp_bus ();

	led_buzzer_pattern_sequencer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// Model of the player: registers, pattern ring, playing pattern, beeps
	cfg_t        cfg;
	pattern_t    ring [RING_DEPTH];
	int          ring_head;
	int          ring_tail;
	logic [3:0]  ring_count;
	pattern_t    now_playing;
	logic [16:0] phase_ms;
	logic [7:0]  cycles_played;
	logic        is_playing;
	logic [6:0]  chime_left;
	logic [2:0]  lit_color;
	logic        tone_on;
	logic [15:0] tone_freq;

	word_out_t   pending_levels [$];
	stim_row_t   stim_table [$];
	int          fails = 0;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	logic [15:0] stall_clock = '0;

	function automatic void reset_model();
		cfg = '{enable: 1'b1, led_enabled: 1'b1, rgb_mode: 1'b1, active_high: 1'b1,
			buzzer_enabled: 1'b1, default_beep_freq_hz: DEFAULT_FREQ_RESET};
		ring_head = 0;
		ring_tail = 0;
		ring_count = '0;
		now_playing = '0;
		phase_ms = '0;
		cycles_played = '0;
		is_playing = 1'b0;
		chime_left = '0;
		lit_color = '0;
		tone_on = 1'b0;
		tone_freq = '0;
	endfunction

	// Any change of the pattern tone cuts the success beep short
	function automatic void drive_tone(input logic on, input logic [15:0] freq);
		if (!cfg.buzzer_enabled || on == tone_on)
			return;
		tone_on = on;
		if (!on)
			tone_freq = '0;
		else if (freq != 0)
			tone_freq = freq;
		else
			tone_freq = cfg.default_beep_freq_hz;
		chime_left = '0;
	endfunction

	function automatic void halt_pattern();
		is_playing = 1'b0;
		lit_color = '0;
		drive_tone(1'b0, 16'd0);
	endfunction

	function automatic void clear_ring();
		ring_head = 0;
		ring_tail = 0;
		ring_count = '0;
	endfunction

	// Advance the playing pattern by one ms, or start the oldest waiting one
	function automatic void advance_ms();
		int cycle_len;
		if (is_playing) begin
			cycle_len = int'(now_playing.on_ms) + int'(now_playing.off_ms);
			if (phase_ms < PHASE_MAX)
				phase_ms = phase_ms + 1'b1;
			if (cycle_len > 0 && int'(phase_ms) >= cycle_len) begin
				cycles_played = cycles_played + 1'b1;
				if (now_playing.repeat_count != REPEAT_FOREVER &&
						cycles_played >= now_playing.repeat_count) begin
					halt_pattern();
					return;
				end
				phase_ms = '0;
			end
			lit_color = (phase_ms < now_playing.on_ms) ? now_playing.color : 3'b000;
			drive_tone(now_playing.beep_ms != 0 && phase_ms < now_playing.beep_ms,
				now_playing.beep_freq_hz);
		end else if (ring_count != 0) begin
			now_playing = ring[ring_head];
			ring_head = (ring_head + 1) % RING_DEPTH;
			ring_count = ring_count - 1'b1;
			cycles_played = '0;
			phase_ms = '0;
			is_playing = 1'b1;
			lit_color = (now_playing.on_ms != 0) ? now_playing.color : 3'b000;
			if (now_playing.beep_ms != 0)
				drive_tone(1'b1, now_playing.beep_freq_hz);
		end
	endfunction

	// Apply one request word to the model and return the pin levels after it
	function automatic word_out_t play_word(input word_in_t w);
		word_out_t o;
		logic      dark;
		o = '0;
		case (w.action)
			ACT_TICK: begin
				if (chime_left != 0)
					chime_left = chime_left - 1'b1;
				if (cfg.enable)
					advance_ms();
			end
			ACT_SUCCESS: begin
				halt_pattern();
				clear_ring();
				if (cfg.enable && cfg.buzzer_enabled)
					chime_left = SUCCESS_MS;
			end
			default: begin
				if (w.action == ACT_CLEAR_QUEUE)
					clear_ring();
				if (cfg.enable) begin
					if (ring_count >= RING_DEPTH) begin
						o.dropped = 1'b1;
					end else begin
						ring[ring_tail] = w.pat;
						ring_tail = (ring_tail + 1) % RING_DEPTH;
						ring_count = ring_count + 1'b1;
					end
				end
			end
		endcase

		dark = ~cfg.active_high;
		if (cfg.led_enabled && cfg.rgb_mode) begin
			o.red = ((lit_color & COLOR_RED) != 0) ^ dark;
			o.green = ((lit_color & COLOR_GREEN) != 0) ^ dark;
			o.blue = ((lit_color & COLOR_BLUE) != 0) ^ dark;
		end else if (cfg.led_enabled) begin
			o.mono = (lit_color != 0) ^ dark;
		end

		if (cfg.buzzer_enabled) begin
			if (tone_on) begin
				o.buzz = 1'b1;
				o.freq = tone_freq;
			end else if (chime_left != 0) begin
				o.buzz = 1'b1;
				o.freq = SUCCESS_TONE_HZ;
			end
		end
		o.active = is_playing;
		o.level = ring_count;
		return o;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	function automatic pattern_t make_pattern(input logic [15:0] on, off, beep, freq,
			input logic [7:0] reps, input logic [2:0] color);
		pattern_t p;
		p.on_ms = on;
		p.off_ms = off;
		p.beep_ms = beep;
		p.beep_freq_hz = freq;
		p.repeat_count = reps;
		p.color = color;
		return p;
	endfunction

	// Tame patterns keep on and off times within 5 ms and beep times within 6 ms; wild ones span the full field ranges
	function automatic pattern_t rand_pattern(input bit tame);
		pattern_t p;
		if (tame) begin
			p.on_ms = 16'($urandom_range(0, 5));
			p.off_ms = 16'($urandom_range(0, 5));
			p.beep_ms = 16'($urandom_range(0, 6));
			p.beep_freq_hz = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
			p.repeat_count = ($urandom_range(0, 9) == 0) ? REPEAT_FOREVER :
				8'($urandom_range(0, 4));
			p.color = 3'($urandom_range(0, 7));
		end else begin
			p.on_ms = 16'($urandom);
			p.off_ms = 16'($urandom);
			p.beep_ms = 16'($urandom);
			p.beep_freq_hz = 16'($urandom);
			p.repeat_count = 8'($urandom);
			p.color = 3'($urandom);
		end
		return p;
	endfunction

	function automatic word_out_t levels_of(input logic r, g, b, m, bz,
			input logic [15:0] f, input logic act, input logic [3:0] lvl, input logic drp);
		word_out_t o;
		o = '{red: r, green: g, blue: b, mono: m, buzz: bz, freq: f, active: act,
			level: lvl, dropped: drp};
		return o;
	endfunction

	function automatic void add_row(input logic [1:0] action, input pattern_t p,
			input int times);
		stim_row_t row;
		row.word = '{action: action, pat: p};
		row.times = times;
		row.typed = 1'b0;
		row.levels = '0;
		stim_table.insert(stim_table.size(), row);
	endfunction

	function automatic void add_checked(input logic [1:0] action, input pattern_t p,
			input word_out_t levels);
		stim_row_t row;
		row.word = '{action: action, pat: p};
		row.times = 1;
		row.typed = 1'b1;
		row.levels = levels;
		stim_table.insert(stim_table.size(), row);
	endfunction

	// Directed words, under the reset setup of the registers
	function automatic void build_table();
		pattern_t none;
		pattern_t widest;
		pattern_t filler;
		none = '0;
		widest = make_pattern(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, REPEAT_FOREVER, 3'b111);
		filler = make_pattern(16'd1, 16'd0, 16'd2, 16'd1, 8'd1, COLOR_BLUE);
		// idle after reset, then a success beep that a starting pattern overrides
		add_checked(ACT_TICK, none, levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0,
			4'd0, 1'b0));
		add_checked(ACT_SUCCESS, none, levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			SUCCESS_TONE_HZ, 1'b0, 4'd0, 1'b0));
		add_row(ACT_TICK, none, 1);
		add_checked(ACT_QUEUE, make_pattern(16'd2, 16'd1, 16'd1, 16'd0, 8'd2, COLOR_RED),
			levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, SUCCESS_TONE_HZ, 1'b0, 4'd1, 1'b0));
		add_checked(ACT_TICK, none, levels_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
			DEFAULT_FREQ_RESET, 1'b1, 4'd0, 1'b0));
		add_row(ACT_TICK, none, 8);
		// repeat count of zero plays one cycle
		add_row(ACT_QUEUE, make_pattern(16'd1, 16'd1, 16'd0, 16'd0, 8'd0, COLOR_GREEN), 1);
		add_row(ACT_TICK, none, 5);
		// no dark time
		add_row(ACT_QUEUE, make_pattern(16'd3, 16'd0, 16'd3, 16'd500, 8'd1,
			COLOR_RED | COLOR_GREEN), 1);
		add_row(ACT_TICK, none, 6);
		// endless pattern, long enough for the cycle count to wrap
		add_row(ACT_QUEUE, make_pattern(16'd1, 16'd1, 16'd1, 16'd7, REPEAT_FOREVER,
			COLOR_BLUE), 1);
		add_row(ACT_TICK, none, 520);
		add_checked(ACT_SUCCESS, none, levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			SUCCESS_TONE_HZ, 1'b0, 4'd0, 1'b0));
		// fill the ring, then one request too many
		add_checked(ACT_QUEUE, widest, levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			SUCCESS_TONE_HZ, 1'b0, 4'd1, 1'b0));
		add_row(ACT_QUEUE, filler, 7);
		add_checked(ACT_QUEUE, filler, levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			SUCCESS_TONE_HZ, 1'b0, 4'd8, 1'b1));
		// zero cycle length plays on forever; its beep ends after 10 ms
		add_checked(ACT_CLEAR_QUEUE, make_pattern(16'd0, 16'd0, 16'd10, 16'd0, 8'd0, 3'b111),
			levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, SUCCESS_TONE_HZ, 1'b0, 4'd1, 1'b0));
		add_checked(ACT_TICK, none, levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			DEFAULT_FREQ_RESET, 1'b1, 4'd0, 1'b0));
		add_row(ACT_TICK, none, 20);
		add_checked(ACT_SUCCESS, none, levels_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			SUCCESS_TONE_HZ, 1'b0, 4'd0, 1'b0));
		add_row(ACT_TICK, none, 85);
	endfunction

	// Present one word in bursts with random gaps; hold it until accepted
	task automatic send_word(input word_in_t w, input bit typed, input word_out_t levels);
		word_out_t guess;
		int        idle_len;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (idle_len > 0) begin
				req_bus.valid <= 1'b0;
				repeat (idle_len) @(posedge clk);
			end
		end
		burst_left--;
		guess = play_word(w);
		pending_levels.insert(pending_levels.size(), typed ? levels : guess);
		req_bus.valid <= 1'b1;
		req_bus.action <= w.action;
		req_bus.on_ms <= w.pat.on_ms;
		req_bus.off_ms <= w.pat.off_ms;
		req_bus.beep_ms <= w.pat.beep_ms;
		req_bus.beep_freq_hz <= w.pat.beep_freq_hz;
		req_bus.repeat_count <= w.pat.repeat_count;
		req_bus.color <= w.pat.color;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
	endtask

	task automatic send_req(input logic [1:0] action, input pattern_t p);
		word_in_t w;
		w.action = action;
		w.pat = p;
		send_word(w, 1'b0, '0);
	endtask

	// Mostly well-formed sequences (queue a few, then tick them out), plus
	// ring floods, success beeps and wild words
	task automatic random_items(input int budget);
		int done_items;
		int pick;
		int n;
		int i;
		done_items = 0;
		while (done_items < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if ($urandom_range(0, 2) == 0) begin
					send_req(ACT_SUCCESS, rand_pattern(1'b0));
					done_items++;
				end
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) begin
					send_req((i == 0 && $urandom_range(0, 3) == 0) ? ACT_CLEAR_QUEUE : ACT_QUEUE,
						rand_pattern(1'b1));
				end
				done_items += n;
				n = $urandom_range(4, 40);
				repeat (n) send_req(ACT_TICK, rand_pattern(1'b0));
				done_items += n;
			end else if (pick < 65) begin
				n = $urandom_range(6, 11);
				repeat (n) send_req(ACT_QUEUE, rand_pattern(1'b1));
				done_items += n;
				n = $urandom_range(1, 6);
				repeat (n) send_req(ACT_TICK, rand_pattern(1'b0));
				done_items += n;
			end else if (pick < 78) begin
				send_req(ACT_SUCCESS, rand_pattern(1'b1));
				n = $urandom_range(1, 90);
				repeat (n) send_req(ACT_TICK, rand_pattern(1'b0));
				done_items += n + 1;
			end else begin
				send_req(2'($urandom_range(0, 3)), rand_pattern(1'b0));
				done_items++;
			end
		end
	endtask

	// Drop valid and wait until every response word is back
	task automatic settle();
		req_bus.valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
	endtask

	// Write a register, then read it back
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_ENABLE:       cfg.enable = val[0];
			REG_LED_ENABLED:  cfg.led_enabled = val[0];
			REG_RGB_MODE:     cfg.rgb_mode = val[0];
			REG_ACTIVE_HIGH:  cfg.active_high = val[0];
			REG_BUZZER_EN:    cfg.buzzer_enabled = val[0];
			REG_DEFAULT_FREQ: cfg.default_beep_freq_hz = val;
			default: ;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		check_field("prdata", 32'(val), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setup(input logic en, led, rgb, high, buzz, input logic [15:0] freq);
		write_reg(REG_ENABLE, 16'(en));
		write_reg(REG_LED_ENABLED, 16'(led));
		write_reg(REG_RGB_MODE, 16'(rgb));
		write_reg(REG_ACTIVE_HIGH, 16'(high));
		write_reg(REG_BUZZER_EN, 16'(buzz));
		write_reg(REG_DEFAULT_FREQ, freq);
	endtask

	// Receiver stalls: free running, coin toss, one in four, mostly ready
	always @(posedge clk) begin
		stall_clock <= stall_clock + 1'b1;
		case (stall_clock[10:9])
			2'd0:    rsp_bus.ready <= 1'b1;
			2'd1:    rsp_bus.ready <= 1'($urandom_range(0, 1));
			2'd2:    rsp_bus.ready <= (stall_clock[1:0] == 2'd0);
			default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Check each accepted response word against the oldest expectation
	always @(posedge clk) begin
		word_out_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_levels.size() == 0) begin
				$display("%0t unexpected response word", $time);
				fails++;
			end else begin
				want = pending_levels.pop_front();
				check_field("red_level", 32'(want.red), 32'(rsp_bus.red_level));
				check_field("green_level", 32'(want.green), 32'(rsp_bus.green_level));
				check_field("blue_level", 32'(want.blue), 32'(rsp_bus.blue_level));
				check_field("mono_level", 32'(want.mono), 32'(rsp_bus.mono_level));
				check_field("buzzer_on", 32'(want.buzz), 32'(rsp_bus.buzzer_on));
				check_field("buzzer_freq_hz", 32'(want.freq), 32'(rsp_bus.buzzer_freq_hz));
				check_field("pattern_active", 32'(want.active), 32'(rsp_bus.pattern_active));
				check_field("queue_level", 32'(want.level), 32'(rsp_bus.queue_level));
				check_field("dropped", 32'(want.dropped), 32'(rsp_bus.dropped));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		req_bus.valid = 1'b0;
		req_bus.action = ACT_TICK;
		req_bus.on_ms = '0;
		req_bus.off_ms = '0;
		req_bus.beep_ms = '0;
		req_bus.beep_freq_hz = '0;
		req_bus.repeat_count = '0;
		req_bus.color = '0;
		rsp_bus.ready = 1'b0;
		reset_model();
		build_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words, then random ones under the reset setup
		foreach (stim_table[i])
			repeat (stim_table[i].times)
				send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].levels);
		random_items(400);
		settle();

		// single LED, active low, default tone of zero
		apply_setup(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0);
		random_items(180);
		settle();

		// no LED and no buzzer fitted
		apply_setup(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF);
		random_items(180);
		settle();

		// block disabled: only success and queue clears act
		apply_setup(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 16'd1234);
		random_items(60);
		settle();

		apply_setup(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'($urandom));
		random_items(180);
		settle();

		apply_setup(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1);
		random_items(180);
		settle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
design/lbps_pkg.sv
design/lbps_channels.sv
design/lbps_front.sv
design/lbps_back.sv
design/led_buzzer_pattern_sequencer.sv
sim/testbench.sv
